>>> rtl/piwm_pkg.sv
`default_nettype none

package piwm_pkg;

  // Default capacity of the process image, in bytes.
  localparam int DEF_IMAGE_BYTES = 1024;

  // Field widths fixed by the item format.
  localparam int OFFSET_W = 10;
  localparam int SIZE_W   = 11;
  localparam int VALUE_W  = 32;

  // Reset value of the image size register.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Write size codes.
  localparam logic [1:0] WC_BIT  = 2'd0;
  localparam logic [1:0] WC_BYTE = 2'd1;
  localparam logic [1:0] WC_HALF = 2'd2;
  localparam logic [1:0] WC_WORD = 2'd3;

  localparam logic [7:0] BYTE_ALL = 8'hff;

endpackage

`default_nettype wire

>>> rtl/process_image_write_merge.sv
`default_nettype none

// Channel   Direction  Handshake               Word
// --------  ---------  ----------------------  -------------------------------------------
// in        sink       in_valid / in_stall     kind, offset, width_code, bit_index,
//                                              write_value, rx_byte
// out       source     out_valid / out_stall   is_data, merged_byte, byte_index,
//                                              rejected, last_of_frame
// cfg       sink       cfg_valid / cfg_ready   cfg_data (image size, 11 bits)
//
// One input word is handled at a time. A received byte or a one-bit write reads
// the mask and cache memories, then modifies the byte and writes it back.
// A byte, 16-bit or 32-bit write makes one memory write per byte through the
// single write port, then responds. A rejected word goes straight to the response.
// After reset a clearing pass writes zero to every entry of both memories, one
// entry per cycle, so no word is accepted until the pass is complete.
// When out_stall holds the output register full, the block waits in its final
// step and keeps the memory read data until the result can be loaded.
module process_image_write_merge #(
  parameter int IMAGE_BYTES = piwm_pkg::DEF_IMAGE_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              kind,
  input  wire logic [piwm_pkg::OFFSET_W-1:0]     offset,
  input  wire logic [1:0]                        width_code,
  input  wire logic [2:0]                        bit_index,
  input  wire logic [piwm_pkg::VALUE_W-1:0]      write_value,
  input  wire logic [7:0]                        rx_byte,
  // Output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   is_data,
  output logic [7:0]                             merged_byte,
  output logic [piwm_pkg::OFFSET_W-1:0]          byte_index,
  output logic                                   rejected,
  output logic                                   last_of_frame,
  // Configuration channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [piwm_pkg::SIZE_W-1:0]       cfg_data
);

  // Memory address width, and working widths for index sums and size compares.
  localparam int AW  = $clog2(IMAGE_BYTES);
  localparam int IW  = (AW > 12) ? AW : 12;
  localparam int SW0 = $clog2(IMAGE_BYTES + 1);
  localparam int CW  = (SW0 > 12) ? SW0 : 12;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state, state_next;

  // Configuration register. Writes are taken at any time.
  logic [piwm_pkg::SIZE_W-1:0] image_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= piwm_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      image_size <= cfg_data;
    end
  end

  // The size in use is the register saturated to the memory depth.
  logic [CW-1:0] eff_size;

  always_comb begin
    if (CW'(image_size) > CW'(IMAGE_BYTES)) begin
      eff_size = CW'(IMAGE_BYTES);
    end else begin
      eff_size = CW'(image_size);
    end
  end

  // Range checks on the incoming word.
  logic [2:0]    in_nbytes;
  logic [CW-1:0] in_span_end;
  logic          in_rejected;
  logic          in_last;

  always_comb begin
    case (width_code)
      piwm_pkg::WC_WORD: in_nbytes = 3'd4;
      piwm_pkg::WC_HALF: in_nbytes = 3'd2;
      default:           in_nbytes = 3'd1;
    endcase
    in_span_end = CW'(offset) + CW'(in_nbytes);
    if (kind == piwm_pkg::KIND_DATA) begin
      in_rejected = (CW'(offset) >= eff_size);
    end else begin
      in_rejected = (in_span_end > eff_size);
    end
    in_last = (CW'(offset) + CW'(1) == eff_size);
  end

  // Registers holding the word in progress.
  logic                          kind_r;
  logic [piwm_pkg::OFFSET_W-1:0] offset_r;
  logic [1:0]                    wcode_r;
  logic [2:0]                    bidx_r;
  logic [piwm_pkg::VALUE_W-1:0]  value_r;
  logic [piwm_pkg::VALUE_W-1:0]  value_sh;
  logic [7:0]                    rx_r;
  logic                          rej_r;
  logic                          last_r;
  logic [1:0]                    byte_cnt;
  logic [1:0]                    byte_last;

  logic in_accept;
  logic out_free;
  logic load_out;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (wcode_r)
      piwm_pkg::WC_WORD: byte_last = 2'd3;
      piwm_pkg::WC_HALF: byte_last = 2'd1;
      default:           byte_last = 2'd0;
    endcase
  end

  // Clearing pass address.
  logic [AW-1:0] clr_addr;

  // Memory ports.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    mask_rd, cache_rd;
  logic          mask_we, cache_we;
  logic [AW-1:0] wr_addr;
  logic [7:0]    mask_wd, cache_wd;

  logic [IW-1:0] in_idx_wide, cur_idx_wide;

  assign in_idx_wide  = IW'(offset);
  assign cur_idx_wide = IW'(offset_r) + IW'(byte_cnt);
  assign rd_addr      = in_idx_wide[AW-1:0];

  logic [7:0] bit_sel;
  logic [7:0] merged_calc;

  assign bit_sel     = 8'b1 << bidx_r;
  assign merged_calc = (rx_r & ~mask_rd) | cache_rd;

  // Result that the final step hands to the output register.
  logic       res_is_data;
  logic [7:0] res_merged;
  logic       res_rejected;
  logic       res_last;

  always_comb begin
    state_next   = state;
    rd_en        = 1'b0;
    mask_we      = 1'b0;
    cache_we     = 1'b0;
    wr_addr      = cur_idx_wide[AW-1:0];
    mask_wd      = 8'h00;
    cache_wd     = 8'h00;
    load_out     = 1'b0;
    res_is_data  = kind_r;
    res_merged   = 8'h00;
    res_rejected = rej_r;
    res_last     = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        // Zero both memories one entry per cycle.
        mask_we  = 1'b1;
        cache_we = 1'b1;
        wr_addr  = clr_addr;
        if (clr_addr == AW'(IMAGE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_rejected) begin
            state_next = ST_RESP;
          end else if (kind == piwm_pkg::KIND_DATA || width_code == piwm_pkg::WC_BIT) begin
            // Both of these need the current mask and cache byte.
            rd_en      = 1'b1;
            state_next = ST_MOD;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_MOD: begin
        // Read data is held until the result can be placed in the output register.
        if (out_free) begin
          load_out = 1'b1;
          mask_we  = 1'b1;
          if (kind_r == piwm_pkg::KIND_DATA) begin
            // The merge consumes the mask; the cache is left as it is.
            mask_wd    = 8'h00;
            res_merged = merged_calc;
            res_last   = last_r;
          end else begin
            cache_we = 1'b1;
            mask_wd  = mask_rd | bit_sel;
            if (value_r != '0) begin
              cache_wd = cache_rd | bit_sel;
            end else begin
              cache_wd = cache_rd & ~bit_sel;
            end
          end
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: begin
        // One byte of a wide write per cycle, least significant byte first.
        mask_we  = 1'b1;
        cache_we = 1'b1;
        mask_wd  = piwm_pkg::BYTE_ALL;
        cache_wd = value_sh[7:0];
        if (byte_cnt == byte_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load_out = 1'b1;
          if (kind_r == piwm_pkg::KIND_DATA) begin
            // An out-of-range received byte passes through unchanged.
            res_merged = rx_r;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      byte_cnt <= 2'd0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (in_accept) begin
        byte_cnt <= 2'd0;
      end else if (state == ST_WRITE) begin
        byte_cnt <= byte_cnt + 2'd1;
      end
    end
  end

  // Word registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r   <= kind;
      offset_r <= offset;
      wcode_r  <= width_code;
      bidx_r   <= bit_index;
      value_r  <= write_value;
      value_sh <= write_value;
      rx_r     <= rx_byte;
      rej_r    <= in_rejected;
      last_r   <= in_last;
    end else if (state == ST_WRITE) begin
      value_sh <= value_sh >> 8;
    end
  end

  // Mask and cache memories, one write and one registered read each.
  logic [7:0] mask_mem  [IMAGE_BYTES];
  logic [7:0] cache_mem [IMAGE_BYTES];

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[wr_addr] <= mask_wd;
    end
    if (rd_en) begin
      mask_rd <= mask_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[wr_addr] <= cache_wd;
    end
    if (rd_en) begin
      cache_rd <= cache_mem[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      is_data       <= res_is_data;
      merged_byte   <= res_merged;
      byte_index    <= offset_r;
      rejected      <= res_rejected;
      last_of_frame <= res_last;
    end
  end

endmodule

`default_nettype wire
